>>> hw/rtl/ack_retry_tracker_unit_defines.svh
// Assertion macros shared by the tracker modules.
`ifndef ACK_RETRY_TRACKER_UNIT_DEFINES_SVH
`define ACK_RETRY_TRACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ART_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tracker assertion failed");
`define ART_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");
`else
`define ART_ASSERT(lbl, prop)
`define ART_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/art_pkg.sv
package art_pkg;

  localparam int ART_SEQ_SLOTS = 256;
  localparam int SEQ_W = 8;
  localparam int CMD_W = 16;
  localparam int RES_W = 8;
  localparam int RETRY_W = 3;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 3'd3;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_ACKED  = 3'd2,
    ACT_RESEND = 3'd3,
    ACT_GIVEUP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } art_cmd_t;

endpackage

>>> hw/rtl/art_ctrl.sv
`include "ack_retry_tracker_unit_defines.svh"

module art_ctrl
  import art_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output art_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.commit = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ART_ASSERT_NEXT(a_accept_to_lookup, in_valid && !in_stall, state == ST_LOOKUP)
  `ART_ASSERT_NEXT(a_lookup_to_emit, state == ST_LOOKUP, out_valid)
  `ART_ASSERT(a_busy_while_result, out_valid |-> in_stall)

endmodule

>>> hw/rtl/art_dp.sv
`include "ack_retry_tracker_unit_defines.svh"

module art_dp
  import art_pkg::*;
#(
  parameter int SEQ_SLOTS = ART_SEQ_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  art_cmd_t           cmd,
  input  logic [1:0]         kind,
  input  logic [SEQ_W-1:0]   seq,
  input  logic [CMD_W-1:0]   cmd_id,
  input  logic [RES_W-1:0]   ack_result,
  input  logic               cfg_we,
  input  logic [RETRY_W-1:0] cfg_data,
  output logic [2:0]         action,
  output logic [SEQ_W-1:0]   out_seq,
  output logic [CMD_W-1:0]   out_cmd,
  output logic [RES_W-1:0]   out_result
);

  localparam int IDX_W = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
  localparam logic [SEQ_W:0] SLOTS_LIMIT = (SEQ_W + 1)'(SEQ_SLOTS);

  logic [RETRY_W-1:0] retry_limit;

  logic [1:0]         kind_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [RES_W-1:0]   res_q;

  logic [CMD_W-1:0]   cmd_mem [SEQ_SLOTS];
  logic [RETRY_W-1:0] ret_mem [SEQ_SLOTS];
  logic [CMD_W-1:0]   rd_cmd;
  logic [RETRY_W-1:0] rd_ret;
  logic [SEQ_SLOTS-1:0] valid;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               in_range;
  logic               hit;

  action_t            act_next;
  logic [SEQ_W-1:0]   oseq_next;
  logic [CMD_W-1:0]   ocmd_next;
  logic [RES_W-1:0]   ores_next;
  logic               valid_set;
  logic               valid_clr;
  logic               cmd_we;
  logic               ret_we;
  logic [RETRY_W-1:0] ret_wdata;
  logic               none_blank;

  assign idx      = seq_q[IDX_W-1:0];
  assign rd_idx   = seq[IDX_W-1:0];
  assign in_range = {1'b0, seq_q} < SLOTS_LIMIT;
  assign hit      = in_range && valid[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      retry_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      seq_q  <= seq;
      cmd_q  <= cmd_id;
      res_q  <= ack_result;
      rd_cmd <= cmd_mem[rd_idx];
      rd_ret <= ret_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_mem[idx] <= cmd_q;
    end
    if (ret_we) begin
      ret_mem[idx] <= ret_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (valid_set) begin
      valid[idx] <= 1'b1;
    end else if (valid_clr) begin
      valid[idx] <= 1'b0;
    end
  end

  always_comb begin
    act_next  = ACT_NONE;
    oseq_next = '0;
    ocmd_next = '0;
    ores_next = '0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    cmd_we    = 1'b0;
    ret_we    = 1'b0;
    ret_wdata = '0;
    case (kind_q)
      KIND_SEND: begin
        if (in_range) begin
          act_next  = ACT_START;
          oseq_next = seq_q;
          valid_set = cmd.commit;
          cmd_we    = cmd.commit;
          ret_we    = cmd.commit;
        end
      end
      KIND_ACK: begin
        if (hit) begin
          act_next  = ACT_ACKED;
          oseq_next = seq_q;
          ocmd_next = cmd_q;
          ores_next = res_q;
          valid_clr = cmd.commit;
        end
      end
      KIND_TIMEOUT: begin
        if (hit) begin
          oseq_next = seq_q;
          if (rd_ret < retry_limit) begin
            act_next  = ACT_RESEND;
            ret_we    = cmd.commit;
            ret_wdata = rd_ret + 3'd1;
          end else begin
            act_next  = ACT_GIVEUP;
            ocmd_next = rd_cmd;
            valid_clr = cmd.commit;
          end
        end
      end
      default: begin
        act_next = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action     <= act_next;
      out_seq    <= oseq_next;
      out_cmd    <= ocmd_next;
      out_result <= ores_next;
    end
  end

  assign none_blank = oseq_next == '0 && ocmd_next == '0 && ores_next == '0 &&
                      !valid_set && !valid_clr;

  `ART_ASSERT(a_none_is_blank, (cmd.commit && act_next == ACT_NONE) |-> none_blank)
  `ART_ASSERT_NEXT(a_release_clears, cmd.commit && valid_clr, !valid[idx])
  `ART_ASSERT_NEXT(a_send_arms, cmd.commit && valid_set, valid[idx] && action == ACT_START)

endmodule

>>> hw/rtl/ack_retry_tracker_unit.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  kind, seq, cmd_id, ack_result
// out      output     out_valid/out_stall  action, out_seq, out_cmd, out_result
// cfg      input      cfg_valid/cfg_ready  cfg_data (retry_limit)
//
// Each item passes from accept to result in order: the accept beat reads
// the command and retry memories, the lookup cycle updates the table and
// loads the result register, then the emit state offers the result beat.
// The next item is taken in the cycle after the result beat, so the single
// memory read port and one-item-at-a-time controller set the rate.
// Reset clears the pending flags and sets retry_limit to 3; no clearing pass.
// out_stall holds the result and keeps in_stall high; cfg_ready is always high.
module ack_retry_tracker_unit
  import art_pkg::*;
#(
  parameter int SEQ_SLOTS = ART_SEQ_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [SEQ_W-1:0]   seq,
  input  logic [CMD_W-1:0]   cmd_id,
  input  logic [RES_W-1:0]   ack_result,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         action,
  output logic [SEQ_W-1:0]   out_seq,
  output logic [CMD_W-1:0]   out_cmd,
  output logic [RES_W-1:0]   out_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RETRY_W-1:0] cfg_data
);

  art_cmd_t cmd;

  assign cfg_ready = 1'b1;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  art_dp #(
    .SEQ_SLOTS (SEQ_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (kind),
    .seq        (seq),
    .cmd_id     (cmd_id),
    .ack_result (ack_result),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .action     (action),
    .out_seq    (out_seq),
    .out_cmd    (out_cmd),
    .out_result (out_result)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import art_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic [CMD_W-1:0] cmd;
    logic [RES_W-1:0] res;
  } event_beat_t;

  typedef struct packed {
    action_t          act;
    logic [SEQ_W-1:0] seq;
    logic [CMD_W-1:0] cmd;
    logic [RES_W-1:0] res;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = '0;
  logic [SEQ_W-1:0]   seq = '0;
  logic [CMD_W-1:0]   cmd_id = '0;
  logic [RES_W-1:0]   ack_result = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         action;
  logic [SEQ_W-1:0]   out_seq;
  logic [CMD_W-1:0]   out_cmd;
  logic [RES_W-1:0]   out_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RETRY_W-1:0] cfg_data = '0;

  ack_retry_tracker_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .seq        (seq),
    .cmd_id     (cmd_id),
    .ack_result (ack_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .out_seq    (out_seq),
    .out_cmd    (out_cmd),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the pending table and the retry limit
  bit                 pend       [ART_SEQ_SLOTS];
  logic [CMD_W-1:0]   pend_cmd   [ART_SEQ_SLOTS];
  logic [RETRY_W-1:0] pend_tries [ART_SEQ_SLOTS];
  logic [RETRY_W-1:0] retry_cap = RETRY_LIMIT_RESET;

  event_beat_t event_q[$];
  outcome_t    outcome_q[$];
  int          sent_total = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic outcome_t track_outcome(input event_beat_t b);
    outcome_t r;
    int i;
    r.act = ACT_NONE;
    r.seq = '0;
    r.cmd = '0;
    r.res = '0;
    i = int'(b.seq);
    if (i < ART_SEQ_SLOTS) begin
      case (b.kind)
        KIND_SEND: begin
          pend[i] = 1'b1;
          pend_cmd[i] = b.cmd;
          pend_tries[i] = '0;
          r.act = ACT_START;
          r.seq = b.seq;
        end
        KIND_ACK: begin
          if (pend[i]) begin
            pend[i] = 1'b0;
            r.act = ACT_ACKED;
            r.seq = b.seq;
            r.cmd = b.cmd;
            r.res = b.res;
          end
        end
        KIND_TIMEOUT: begin
          if (pend[i]) begin
            if (pend_tries[i] < retry_cap) begin
              pend_tries[i] = pend_tries[i] + 1'b1;
              r.act = ACT_RESEND;
              r.seq = b.seq;
            end else begin
              pend[i] = 1'b0;
              r.act = ACT_GIVEUP;
              r.seq = b.seq;
              r.cmd = pend_cmd[i];
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // driver: bursts of beats with random gaps
  event_beat_t cur;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(track_outcome(cur));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          cur = event_q.pop_front();
          kind <= cur.kind;
          seq <= cur.seq;
          cmd_id <= cur.cmd;
          ack_result <= cur.res;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result beats and drive the stall pattern
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing outstanding: action %0d seq %0d", action, out_seq);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, action);
            errors++;
          end
          if (out_seq !== want.seq) begin
            $error("out_seq: expected %0d, got %0d", want.seq, out_seq);
            errors++;
          end
          if (out_cmd !== want.cmd) begin
            $error("out_cmd: expected %0h, got %0h", want.cmd, out_cmd);
            errors++;
          end
          if (out_result !== want.res) begin
            $error("out_result: expected %0h, got %0h", want.res, out_result);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && results_seen >= 300) begin
        // hold off long enough to back the block up into its input
        held_once = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 999) == 0) begin
        hold_left = $urandom_range(50, 250);
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] k, input logic [SEQ_W-1:0] s,
                          input logic [CMD_W-1:0] c, input logic [RES_W-1:0] r);
    event_beat_t b;
    b.kind = k;
    b.seq = s;
    b.cmd = c;
    b.res = r;
    event_q.push_back(b);
    sent_total++;
  endtask

  task automatic add_noise();
    add_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 7) return SEQ_W'($urandom_range(0, 7));
    return SEQ_W'($urandom);
  endfunction

  task automatic wait_drained();
    while (results_seen != sent_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [RETRY_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    retry_cap = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int lim);
    int stop_at;
    int k;
    int j;
    logic [SEQ_W-1:0] s;
    stop_at = sent_total + n;
    while (sent_total < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        s = pick_seq();
        add_item(KIND_SEND, s, 16'($urandom), 8'($urandom));
        k = $urandom_range(0, lim + 1);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 4) == 0) add_noise();
          if ($urandom_range(0, 9) == 0) add_item(KIND_SEND, s, 16'($urandom), 8'($urandom));
          add_item(KIND_TIMEOUT, s, 16'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 2) != 0) add_item(KIND_ACK, s, 16'($urandom), 8'($urandom));
      end else begin
        add_noise();
      end
    end
  endtask

  initial begin
    int lims[6];
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset limit of three
    add_item(KIND_SEND, 8'd0, 16'h0000, 8'h00);
    add_item(KIND_SEND, 8'd255, 16'hFFFF, 8'hFF);
    add_item(KIND_ACK, 8'd0, 16'hFFFF, 8'hFF);
    add_item(KIND_ACK, 8'd0, 16'h0001, 8'h01);
    add_item(KIND_TIMEOUT, 8'd7, 16'h0000, 8'h00);
    add_item(KIND_UNUSED, 8'd255, 16'hFFFF, 8'hFF);
    repeat (4) add_item(KIND_TIMEOUT, 8'd255, 16'h0000, 8'h00);
    add_item(KIND_TIMEOUT, 8'd255, 16'h0000, 8'h00);
    add_item(KIND_SEND, 8'd10, 16'h1234, 8'h00);
    add_item(KIND_SEND, 8'd10, 16'hABCD, 8'h00);
    add_item(KIND_TIMEOUT, 8'd10, 16'h0000, 8'h00);
    add_item(KIND_SEND, 8'd10, 16'h5555, 8'h00);
    add_item(KIND_ACK, 8'd10, 16'h0000, 8'h00);

    // zero limit: first expiry gives up
    write_limit(3'd0);
    add_item(KIND_SEND, 8'd1, 16'h0F0F, 8'h00);
    add_item(KIND_TIMEOUT, 8'd1, 16'h0000, 8'h00);
    add_item(KIND_ACK, 8'd1, 16'h0000, 8'h00);

    write_limit(3'd7);
    add_item(KIND_SEND, 8'd2, 16'hF0F0, 8'h00);
    repeat (8) add_item(KIND_TIMEOUT, 8'd2, 16'h0000, 8'h00);

    lims[0] = 7;
    lims[1] = 0;
    lims[2] = $urandom_range(0, 7);
    lims[3] = 1;
    lims[4] = $urandom_range(0, 7);
    lims[5] = 4;
    for (p = 0; p < 6; p++) begin
      write_limit(RETRY_W'(lims[p]));
      run_phase(235, lims[p]);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $error("outcomes left outstanding: %0d", outcome_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> ack_retry_tracker_unit.f
+incdir+hw/rtl
hw/rtl/art_pkg.sv
hw/rtl/art_ctrl.sv
hw/rtl/art_dp.sv
hw/rtl/ack_retry_tracker_unit.sv
sim/testbench.sv
